@@ hw/rtl/rbv_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rbv_pkg
// Shared types, constants and the basis-check step table for the rigid-body
// record validator.
// ----------------------------------------------------------------------------
package rbv_pkg;

    localparam int FRAC_BITS_DEF = 30;
    localparam int ROT_DEPTH     = 9;
    localparam int ROT_AW        = 4;
    localparam int TOL_W         = 20;
    localparam int CFG_IDX_W     = 2;
    localparam int NUM_STEPS     = 27;
    localparam int STEP_W        = 5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LEN_TOL  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORTH_TOL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DET_TOL  = 2'd2;

    localparam logic [TOL_W-1:0] LEN_TOL_RST  = 20'd26214;
    localparam logic [TOL_W-1:0] ORTH_TOL_RST = 20'd26214;
    localparam logic [TOL_W-1:0] DET_TOL_RST  = 20'd78643;

    // record slots
    localparam logic [4:0] SLOT_POS_LO  = 5'd0;
    localparam logic [4:0] SLOT_POS_HI  = 5'd2;
    localparam logic [4:0] SLOT_ROT_LO  = 5'd3;
    localparam logic [4:0] SLOT_ROT_HI  = 5'd11;
    localparam logic [4:0] SLOT_VEL_LO  = 5'd12;
    localparam logic [4:0] SLOT_VEL_HI  = 5'd14;
    localparam logic [4:0] SLOT_ANG_LO  = 5'd15;
    localparam logic [4:0] SLOT_ANG_HI  = 5'd17;
    localparam logic [4:0] SLOT_COM_LO  = 5'd18;
    localparam logic [4:0] SLOT_COM_HI  = 5'd20;
    localparam logic [4:0] SLOT_MASS    = 5'd21;
    localparam logic [4:0] SLOT_FRIC    = 5'd22;
    localparam logic [4:0] SLOT_BOUNCE  = 5'd23;
    localparam logic [4:0] SLOT_STATE   = 5'd24;
    localparam logic [4:0] SLOT_SOUND   = 5'd25;
    localparam logic [4:0] SLOT_UWATER  = 5'd26;
    localparam logic [4:0] SLOT_LAST    = 5'd27;

    // float32 bit patterns of the bounds
    localparam logic [31:0] F_2P20     = 32'h4980_0000;
    localparam logic [31:0] F_2P16     = 32'h4780_0000;
    localparam logic [31:0] F_MASS_MIN = 32'h38D1_B717;
    localparam logic [31:0] F_MASS_MAX = 32'h4974_2400;
    localparam logic [31:0] F_FRIC_MAX = 32'h461C_4000;
    localparam logic [31:0] F_FLT_MAX  = 32'h7F7F_FFFF;
    localparam logic [31:0] F_ONE      = 32'h3F80_0000;
    localparam logic [31:0] F_ROT_MAX  = 32'h3F80_20C5;
    localparam logic [31:0] NEG_ZERO   = 32'h8000_0000;
    localparam logic [31:0] STATE_MAX  = 32'd2;
    localparam logic [31:0] SOUND_MAX  = 32'd49;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_FIN
    } t_state;

    typedef enum logic [2:0] {
        CHK_NONE,
        CHK_COF,
        CHK_LEN,
        CHK_ORTH,
        CHK_DET
    } t_chk;

    typedef struct packed {
        logic [ROT_AW-1:0] addr_a;
        logic [ROT_AW-1:0] addr_b;
        logic              use_cof;
        logic [1:0]        cof_idx;
        logic              sub;
        logic              first;
        t_chk              chk;
    } t_step;

    typedef struct packed {
        logic              in_ready;
        logic              accept;
        logic              issue;
        logic [STEP_W-1:0] step;
        logic              load_out;
    } t_cmd;

    typedef struct packed {
        logic busy;
        logic out_free;
    } t_stat;

    function automatic t_step mk_step(input logic [ROT_AW-1:0] a, input logic [ROT_AW-1:0] b,
                                      input logic uc, input logic [1:0] ci, input logic sb,
                                      input logic fs, input t_chk ck);
        t_step s;
        s.addr_a  = a;
        s.addr_b  = b;
        s.use_cof = uc;
        s.cof_idx = ci;
        s.sub     = sb;
        s.first   = fs;
        s.chk     = ck;
        return s;
    endfunction

    // cofactors first, then row lengths, row dot products, determinant
    function automatic t_step step_info(input logic [STEP_W-1:0] k);
        t_step s;
        case (k)
            5'd0:  s = mk_step(4'd4, 4'd8, 1'b0, 2'd0, 1'b0, 1'b1, CHK_NONE);
            5'd1:  s = mk_step(4'd5, 4'd7, 1'b0, 2'd0, 1'b1, 1'b0, CHK_COF);
            5'd2:  s = mk_step(4'd3, 4'd8, 1'b0, 2'd1, 1'b0, 1'b1, CHK_NONE);
            5'd3:  s = mk_step(4'd5, 4'd6, 1'b0, 2'd1, 1'b1, 1'b0, CHK_COF);
            5'd4:  s = mk_step(4'd3, 4'd7, 1'b0, 2'd2, 1'b0, 1'b1, CHK_NONE);
            5'd5:  s = mk_step(4'd4, 4'd6, 1'b0, 2'd2, 1'b1, 1'b0, CHK_COF);
            5'd6:  s = mk_step(4'd0, 4'd0, 1'b0, 2'd0, 1'b0, 1'b1, CHK_NONE);
            5'd7:  s = mk_step(4'd1, 4'd1, 1'b0, 2'd0, 1'b0, 1'b0, CHK_NONE);
            5'd8:  s = mk_step(4'd2, 4'd2, 1'b0, 2'd0, 1'b0, 1'b0, CHK_LEN);
            5'd9:  s = mk_step(4'd3, 4'd3, 1'b0, 2'd0, 1'b0, 1'b1, CHK_NONE);
            5'd10: s = mk_step(4'd4, 4'd4, 1'b0, 2'd0, 1'b0, 1'b0, CHK_NONE);
            5'd11: s = mk_step(4'd5, 4'd5, 1'b0, 2'd0, 1'b0, 1'b0, CHK_LEN);
            5'd12: s = mk_step(4'd6, 4'd6, 1'b0, 2'd0, 1'b0, 1'b1, CHK_NONE);
            5'd13: s = mk_step(4'd7, 4'd7, 1'b0, 2'd0, 1'b0, 1'b0, CHK_NONE);
            5'd14: s = mk_step(4'd8, 4'd8, 1'b0, 2'd0, 1'b0, 1'b0, CHK_LEN);
            5'd15: s = mk_step(4'd0, 4'd3, 1'b0, 2'd0, 1'b0, 1'b1, CHK_NONE);
            5'd16: s = mk_step(4'd1, 4'd4, 1'b0, 2'd0, 1'b0, 1'b0, CHK_NONE);
            5'd17: s = mk_step(4'd2, 4'd5, 1'b0, 2'd0, 1'b0, 1'b0, CHK_ORTH);
            5'd18: s = mk_step(4'd0, 4'd6, 1'b0, 2'd0, 1'b0, 1'b1, CHK_NONE);
            5'd19: s = mk_step(4'd1, 4'd7, 1'b0, 2'd0, 1'b0, 1'b0, CHK_NONE);
            5'd20: s = mk_step(4'd2, 4'd8, 1'b0, 2'd0, 1'b0, 1'b0, CHK_ORTH);
            5'd21: s = mk_step(4'd3, 4'd6, 1'b0, 2'd0, 1'b0, 1'b1, CHK_NONE);
            5'd22: s = mk_step(4'd4, 4'd7, 1'b0, 2'd0, 1'b0, 1'b0, CHK_NONE);
            5'd23: s = mk_step(4'd5, 4'd8, 1'b0, 2'd0, 1'b0, 1'b0, CHK_ORTH);
            5'd24: s = mk_step(4'd0, 4'd0, 1'b1, 2'd0, 1'b0, 1'b1, CHK_NONE);
            5'd25: s = mk_step(4'd1, 4'd0, 1'b1, 2'd1, 1'b1, 1'b0, CHK_NONE);
            5'd26: s = mk_step(4'd2, 4'd0, 1'b1, 2'd2, 1'b0, 1'b0, CHK_DET);
            default: s = mk_step(4'd0, 4'd0, 1'b0, 2'd0, 1'b0, 1'b1, CHK_NONE);
        endcase
        return s;
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/rbv_in_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rbv_in_if
// Input channel: one record word tagged with its slot.
// ----------------------------------------------------------------------------
interface rbv_in_if;
    logic        valid;
    logic        ready;
    logic [4:0]  slot;
    logic [31:0] word;

    modport source (output valid, output slot, output word, input ready);
    modport sink   (input valid, input slot, input word, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/rbv_out_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rbv_out_if
// Result channel: record verdict and masked underwater bit.
// ----------------------------------------------------------------------------
interface rbv_out_if;
    logic valid;
    logic ready;
    logic record_ok;
    logic underwater_bit;

    modport source (output valid, output record_ok, output underwater_bit, input ready);
    modport sink   (input valid, input record_ok, input underwater_bit, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/rbv_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rbv_ram
// Generic RAM: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module rbv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 9
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]         o_rdata_a,
    output logic      [WIDTH-1:0]         o_rdata_b
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end
endmodule
`default_nettype wire

@@ hw/rtl/rbv_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rbv_ctrl
// Sequencer: takes words, then steps the basis check through the datapath.
// ----------------------------------------------------------------------------
module rbv_ctrl
    import rbv_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic [4:0] i_slot,
    input  wire t_stat      i_stat,
    output t_cmd            o_cmd
);
    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step,  n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state = r_state;
        n_step  = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid && i_slot == SLOT_LAST) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                n_step = r_step + 1'b1;
                if (r_step == STEP_W'(NUM_STEPS - 1)) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!i_stat.busy) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                // hold until the output register can take the verdict
                if (i_stat.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.step     = r_step;
        case (r_state)
            ST_IDLE: begin
                o_cmd.in_ready = 1'b1;
                o_cmd.accept   = i_in_valid;
            end
            ST_RUN:   o_cmd.issue    = 1'b1;
            ST_DRAIN: o_cmd.issue    = 1'b0;
            ST_FIN:   o_cmd.load_out = i_stat.out_free;
            default:  o_cmd.issue    = 1'b0;
        endcase
    end

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_RUN |-> r_step < STEP_W'(NUM_STEPS))
        else $error("step counter past end of table");
    a_run_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == ST_RUN) |-> $past(o_cmd.accept && i_slot == SLOT_LAST))
        else $error("check started without a last-slot transaction");
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |=> r_state == ST_IDLE)
        else $error("controller did not return to idle after load");
endmodule
`default_nettype wire

@@ hw/rtl/rbv_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rbv_datapath
// Word range checks, rotation store, shared multiply-accumulate for the
// basis check, tolerance registers and the result register.
// ----------------------------------------------------------------------------
module rbv_datapath
    import rbv_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_cmd                 i_cmd,
    output t_stat                     o_stat,
    input  wire logic [4:0]           i_slot,
    input  wire logic [31:0]          i_word,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [TOL_W-1:0]     i_cfg_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic                      o_record_ok,
    output logic                      o_underwater_bit
);
    localparam int W   = FRAC_BITS + 2;
    localparam int CW  = W + 1;
    localparam int PW  = 2 * CW;
    localparam int AW  = PW + 2;
    localparam int TSH = 2 * FRAC_BITS - TOL_W;

    logic [TOL_W-1:0] r_len_tol, r_orth_tol, r_det_tol;
    logic             r_run_ok, r_uw, r_basis_ok;

    // ---------------- word checks ----------------
    logic          word_ok;
    logic [30:0]   mag;
    logic          rot_we;
    logic [W-1:0]  rot_fix;
    logic [W-1:0]  rot_wdata;

    assign mag = i_word[30:0];

    always_comb begin
        word_ok = 1'b1;
        if (i_slot <= SLOT_POS_HI || (i_slot >= SLOT_VEL_LO && i_slot <= SLOT_VEL_HI) ||
            (i_slot >= SLOT_COM_LO && i_slot <= SLOT_COM_HI)) begin
            word_ok = {1'b0, mag} <= F_2P20;
        end else if (i_slot <= SLOT_ROT_HI) begin
            word_ok = {1'b0, mag} <= F_ROT_MAX;
        end else if (i_slot <= SLOT_ANG_HI) begin
            word_ok = {1'b0, mag} <= F_2P16;
        end else if (i_slot == SLOT_MASS) begin
            word_ok = i_word >= F_MASS_MIN && i_word <= F_MASS_MAX;
        end else if (i_slot == SLOT_FRIC) begin
            word_ok = i_word <= F_FRIC_MAX || i_word == NEG_ZERO || i_word == F_FLT_MAX;
        end else if (i_slot == SLOT_BOUNCE) begin
            word_ok = i_word <= F_ONE || i_word == NEG_ZERO;
        end else if (i_slot == SLOT_STATE) begin
            word_ok = i_word <= STATE_MAX;
        end else if (i_slot == SLOT_SOUND) begin
            word_ok = i_word <= SOUND_MAX;
        end else if (i_slot == SLOT_UWATER) begin
            word_ok = i_word[7:0] <= 8'd1;
        end else begin
            word_ok = !i_word[31];
        end
    end

    // float to fixed, truncated toward zero
    always_comb begin
        logic [63:0] mant;
        logic [63:0] m_abs;
        int          sh;
        mant = {40'd0, 1'b1, i_word[22:0]};
        sh   = int'(i_word[30:23]) - 150 + FRAC_BITS;
        if (i_word[30:23] == 8'd0) begin
            m_abs = '0;
        end else if (sh >= 0) begin
            m_abs = mant << sh;
        end else if (-sh >= 24) begin
            m_abs = '0;
        end else begin
            m_abs = mant >> (-sh);
        end
        if (i_word[31]) begin
            m_abs = -m_abs;
        end
        rot_fix = m_abs[W-1:0];
    end

    assign rot_we    = i_cmd.accept && i_slot >= SLOT_ROT_LO && i_slot <= SLOT_ROT_HI;
    assign rot_wdata = word_ok ? rot_fix : '0;

    // ---------------- basis check pipeline ----------------
    t_step             st0, r_st1, r_st2;
    logic              r_v1, r_v2;
    logic [W-1:0]      rd_a, rd_b;
    logic signed [CW-1:0] r_cof [3];
    logic signed [CW-1:0] mul_a, mul_b;
    logic signed [PW-1:0] r_prod;
    logic signed [AW-1:0] r_acc, acc_base, acc_val, prod_ext, centre, tol_sh;
    logic [TOL_W-1:0]  tol_sel;
    logic              in_tol;

    assign st0 = step_info(i_cmd.step);

    rbv_ram #(.WIDTH(W), .DEPTH(ROT_DEPTH)) u_rot_ram (
        .i_clk     (i_clk),
        .i_we      (rot_we),
        .i_waddr   (ROT_AW'(i_slot - SLOT_ROT_LO)),
        .i_wdata   (rot_wdata),
        .i_raddr_a (st0.addr_a),
        .i_raddr_b (st0.addr_b),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    assign mul_a = {rd_a[W-1], rd_a};
    assign mul_b = r_st1.use_cof ? r_cof[r_st1.cof_idx] : {rd_b[W-1], rd_b};

    assign prod_ext = AW'(r_prod);
    assign acc_base = r_st2.first ? '0 : r_acc;
    assign acc_val  = r_st2.sub ? acc_base - prod_ext : acc_base + prod_ext;

    always_comb begin
        centre  = '0;
        tol_sel = r_orth_tol;
        case (r_st2.chk)
            CHK_LEN: begin
                centre  = AW'(1) <<< (2 * FRAC_BITS);
                tol_sel = r_len_tol;
            end
            CHK_DET: begin
                centre  = AW'(1) <<< (2 * FRAC_BITS);
                tol_sel = r_det_tol;
            end
            default: begin
                centre  = '0;
                tol_sel = r_orth_tol;
            end
        endcase
    end

    assign tol_sh = AW'(tol_sel) <<< TSH;
    assign in_tol = acc_val >= centre - tol_sh && acc_val <= centre + tol_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_st1 <= st0;
        if (r_v1) begin
            r_prod <= mul_a * mul_b;
            r_st2  <= r_st1;
        end
        if (r_v2) begin
            r_acc <= acc_val;
            if (r_st2.chk == CHK_COF) begin
                r_cof[r_st2.cof_idx] <= CW'(acc_val >>> FRAC_BITS);
            end
        end
    end

    // ---------------- record flags, config, result ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_tol   <= LEN_TOL_RST;
            r_orth_tol  <= ORTH_TOL_RST;
            r_det_tol   <= DET_TOL_RST;
            r_run_ok    <= 1'b1;
            r_uw        <= 1'b0;
            r_basis_ok  <= 1'b1;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_LEN_TOL:  r_len_tol  <= i_cfg_data;
                    CFG_ORTH_TOL: r_orth_tol <= i_cfg_data;
                    CFG_DET_TOL:  r_det_tol  <= i_cfg_data;
                    default:      r_len_tol  <= r_len_tol;
                endcase
            end
            if (i_cmd.accept && i_slot <= SLOT_LAST) begin
                r_run_ok <= r_run_ok & word_ok;
                if (i_slot == SLOT_UWATER) begin
                    r_uw <= i_word[0];
                end
            end
            if (r_v2 && r_st2.chk != CHK_NONE && r_st2.chk != CHK_COF && !in_tol) begin
                r_basis_ok <= 1'b0;
            end
            if (i_cmd.load_out) begin
                o_out_valid <= 1'b1;
                r_run_ok    <= 1'b1;
                r_uw        <= 1'b0;
                r_basis_ok  <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_record_ok      <= r_run_ok & r_basis_ok;
            o_underwater_bit <= r_run_ok & r_basis_ok & r_uw;
        end
    end

    assign o_stat.busy     = r_v1 | r_v2;
    assign o_stat.out_free = !o_out_valid | i_out_ready;

    a_out_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_cmd.load_out))
        else $error("result appeared without a load");
    a_flags_rearm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |=> r_run_ok && r_basis_ok && !r_uw)
        else $error("record flags not rearmed after result");
endmodule
`default_nettype wire

@@ hw/rtl/rigid_body_record_validator.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rigid_body_record_validator
// Checks a 28-word rigid-body record and its rotation basis; one verdict per
// record.
// ----------------------------------------------------------------------------
//  channel   dir  width        payload
//  i_in      in   5 + 32       slot, word
//  o_out     out  1 + 1        record_ok, underwater_bit
//  i_cfg_*   in   2 + 20       register index, tolerance
//
//  Words are taken one per cycle while the sequencer is idle. After the
//  last-slot word the shared multiplier walks 27 products (cofactors, row
//  lengths, dot products, determinant) through a three-stage pipeline; no
//  word is taken while the products issue, the pipeline drains and the
//  verdict loads.
//  Reset is synchronous, active low; the rotation store is not cleared.
//  A waiting result still lets the next record's words in; that record's
//  verdict then holds, and no word is taken until the result register frees.
// ----------------------------------------------------------------------------
module rigid_body_record_validator
    import rbv_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    rbv_in_if.sink                    i_in,
    rbv_out_if.source                 o_out,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [TOL_W-1:0]     i_cfg_data
);
    t_cmd  cmd;
    t_stat stat;

    rbv_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_slot     (i_in.slot),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    rbv_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_slot           (i_in.slot),
        .i_word           (i_in.word),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .o_out_valid      (o_out.valid),
        .i_out_ready      (o_out.ready),
        .o_record_ok      (o_out.record_ok),
        .o_underwater_bit (o_out.underwater_bit)
    );

    assign i_in.ready = cmd.in_ready;
endmodule
`default_nettype wire
